>>> rtl/bli_pkg.sv
// shared types, constants and level ladders for the battery level indicator
`default_nettype none

package bli_pkg;

  localparam int unsigned ChanW   = 2;
  localparam int unsigned RawW    = 16;
  localparam int unsigned VoltW   = 14;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned DisSteps = 10;
  localparam int unsigned ChgSteps = 4;

  typedef logic [VoltW-1:0]  volt_t;
  typedef logic [LevelW-1:0] level_t;

  typedef enum logic [ChanW-1:0] {
    CH_AUX0  = 2'd0,
    CH_AUX1  = 2'd1,
    CH_SENSE = 2'd2,
    CH_BATT  = 2'd3
  } chan_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHARGE_ON_BELOW  = 1'b0,
    CFG_CHARGE_OFF_ABOVE = 1'b1
  } cfg_idx_e;

  localparam volt_t  ResetOnBelow  = 14'd500;
  localparam volt_t  ResetOffAbove = 14'd1000;
  localparam volt_t  ResetHeld     = 14'd4200;
  localparam level_t LevelFull     = 4'd10;

  localparam volt_t DisThr [DisSteps] = '{
    14'd3600, 14'd3638, 14'd3678, 14'd3716, 14'd3748,
    14'd3786, 14'd3827, 14'd3873, 14'd3899, 14'd3939
  };
  localparam volt_t  ChgThr [ChgSteps] = '{14'd4000, 14'd4023, 14'd4072, 14'd4160};
  localparam level_t ChgLvl [ChgSteps] = '{4'd2, 4'd4, 4'd7, 4'd10};

  typedef struct packed {
    chan_e channel;
    volt_t scaled;
  } sample_t;

  typedef struct packed {
    logic   charging;
    level_t level;
    volt_t  held_voltage;
    logic   changed;
  } result_t;

  // (raw >> 4) * 3 as a shift and add, at most 12285
  function automatic volt_t scale_raw(logic [RawW-1:0] raw);
    return {2'b00, raw[RawW-1:4]} + {1'b0, raw[RawW-1:4], 1'b0};
  endfunction

  // discharge ladder: thresholds ascend, so the level is the last one passed
  function automatic level_t dis_level(volt_t v);
    level_t lvl;
    lvl = '0;
    for (int i = 0; i < DisSteps; i++) begin
      if (v > DisThr[i]) lvl = level_t'(i + 1);
    end
    return lvl;
  endfunction

  function automatic level_t chg_level(volt_t v);
    level_t lvl;
    lvl = '0;
    for (int i = 0; i < ChgSteps; i++) begin
      if (v > ChgThr[i]) lvl = ChgLvl[i];
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bli_in_stage.sv
// input register: takes one beat and holds the scaled sample until the next stage takes it
`default_nettype none

module bli_in_stage
  import bli_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire logic [ChanW-1:0] channel_i,
  input  wire logic [RawW-1:0] raw_sample_i,
  input  wire logic            advance_i,
  output      logic            valid_o,
  output      sample_t         sample_o
);

  logic    valid_q, valid_d;
  sample_t sample_q;
  logic    take;

  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take)           valid_d = 1'b1;
    else if (advance_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sample_q.channel <= chan_e'(channel_i);
      sample_q.scaled  <= scale_raw(raw_sample_i);
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;

endmodule

`default_nettype wire

>>> rtl/bli_track.sv
// tracking state: stored samples, charger flag, level ladders and held voltage
`default_nettype none

module bli_track
  import bli_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [VoltW-1:0]   cfg_data_i,
  input  wire logic               upd_i,
  input  wire sample_t            sample_i,
  output      result_t            result_o
);

  volt_t  on_below_q, off_above_q;
  volt_t  sense_q, sense_d;
  volt_t  batt_q, batt_d;
  logic   flag_q, flag_d;
  level_t level_q, level_d;
  volt_t  held_q, held_d;

  always_comb begin
    sense_d = (sample_i.channel == CH_SENSE) ? sample_i.scaled : sense_q;
    batt_d  = (sample_i.channel == CH_BATT)  ? sample_i.scaled : batt_q;

    // clear wins when both thresholds are hit
    priority if (sense_d > off_above_q) flag_d = 1'b0;
    else if (sense_d < on_below_q)      flag_d = 1'b1;
    else                                flag_d = flag_q;

    if (flag_d) begin
      level_d = chg_level(batt_d);
      held_d  = (batt_d < held_q) ? held_q : batt_d;
    end else begin
      level_d = dis_level(batt_d);
      held_d  = (batt_d > held_q) ? held_q : batt_d;
    end

    result_o.charging     = flag_d;
    result_o.level        = level_d;
    result_o.held_voltage = held_d;
    result_o.changed      = (level_d != level_q) || (flag_d != flag_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_below_q  <= ResetOnBelow;
      off_above_q <= ResetOffAbove;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CHARGE_ON_BELOW:  on_below_q  <= cfg_data_i;
        CFG_CHARGE_OFF_ABOVE: off_above_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_q <= '0;
      batt_q  <= '0;
      flag_q  <= 1'b0;
      level_q <= LevelFull;
      held_q  <= ResetHeld;
    end else if (upd_i) begin
      sense_q <= sense_d;
      batt_q  <= batt_d;
      flag_q  <= flag_d;
      level_q <= level_d;
      held_q  <= held_d;
    end
  end

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelFull) else $error("level beyond full");

  a_held_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && !flag_d |=> held_q <= $past(held_q))
    else $error("held voltage rose while discharging");

  a_held_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && flag_d |=> held_q >= $past(held_q))
    else $error("held voltage fell while charging");

endmodule

`default_nettype wire

>>> rtl/battery_level_indicator_core.sv
// top level of the battery level indicator: input stage, tracking logic, result register
`default_nettype none

// Takes one converter beat per clock and returns one result beat per input beat, in order.
// The input register holds the scaled sample, and the charger flag, level ladders and
// held-voltage clamp are evaluated in one pass into the result register.
// Throughput is one beat per cycle; the only limit is the result register, so out_stall_i
// held high stops intake once both registers are full. The tracking state advances when a
// sample moves into the result register. Thresholds are written on the cfg port while idle.

module battery_level_indicator_core
  import bli_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [VoltW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [ChanW-1:0]   channel_i,
  input  wire logic [RawW-1:0]    raw_sample_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic               charging_o,
  output      logic [LevelW-1:0]  level_o,
  output      logic [VoltW-1:0]   held_voltage_o,
  output      logic               changed_o
);

  logic    s1_valid;
  sample_t s1_sample;
  logic    advance;
  result_t result;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  // result register is free when empty or its beat leaves this cycle
  assign advance = s1_valid && (!out_valid_q || !out_stall_i);

  bli_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .channel_i    (channel_i),
    .raw_sample_i (raw_sample_i),
    .advance_i    (advance),
    .valid_o      (s1_valid),
    .sample_o     (s1_sample)
  );

  bli_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .upd_i      (advance),
    .sample_i   (s1_sample),
    .result_o   (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance)          out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= result;
  end

  assign out_valid_o    = out_valid_q;
  assign charging_o     = out_q.charging;
  assign level_o        = out_q.level;
  assign held_voltage_o = out_q.held_voltage;
  assign changed_o      = out_q.changed;

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> !in_stall_o) else $error("intake stalled with empty input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !advance)
    else $error("result register overwritten while stalled");

  a_fill_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid && (!out_valid_q || !out_stall_i) |=> !out_valid_q)
    else $error("result beat appeared without a sample");

endmodule

`default_nettype wire

>>> test/battery_level_indicator_core_chk.sv
// checker for the battery level indicator: predicts every result beat and compares it
`timescale 1ns / 100ps

module battery_level_indicator_core_chk
  import bli_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [VoltW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [ChanW-1:0]   channel_i,
  input  logic [RawW-1:0]    raw_sample_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic               charging_o,
  input  logic [LevelW-1:0]  level_o,
  input  logic [VoltW-1:0]   held_voltage_o,
  input  logic               changed_o,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam int DIS_STEP_MV [10] = '{3600, 3638, 3678, 3716, 3748,
                                      3786, 3827, 3873, 3899, 3939};
  localparam int CHG_STEP_MV  [4] = '{4000, 4023, 4072, 4160};
  localparam int CHG_STEP_LVL [4] = '{2, 4, 7, 10};

  volt_t   on_below_mv;
  volt_t   off_above_mv;
  volt_t   sense_mv;
  volt_t   batt_mv;
  volt_t   held_mv;
  logic    charger_seen;
  level_t  shown_level;
  result_t readings_q[$];
  result_t want;
  result_t got;
  result_t next_reading;
  int      mismatches = 0;

  assign pending_o    = readings_q.size();
  assign fail_count_o = mismatches;

  // advances the tracking state by one sample and returns the reading it yields
  task automatic track_sample(input chan_e ch, input logic [RawW-1:0] raw,
                              output result_t r);
    int     mv;
    logic   was_charging;
    level_t was_level;
    level_t lvl;
    volt_t  shown;
    mv = (int'(raw) >> 4) * 3;
    was_charging = charger_seen;
    was_level = shown_level;
    if (ch == CH_SENSE) sense_mv = volt_t'(mv);
    else if (ch == CH_BATT) batt_mv = volt_t'(mv);
    if (sense_mv < on_below_mv) charger_seen = 1'b1;
    // clear wins when both thresholds are crossed
    if (sense_mv > off_above_mv) charger_seen = 1'b0;
    lvl = '0;
    shown = batt_mv;
    if (!charger_seen) begin
      for (int i = 0; i < 10; i++) begin
        if (batt_mv > DIS_STEP_MV[i]) lvl = level_t'(i + 1);
      end
      if (shown > held_mv) shown = held_mv;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (batt_mv > CHG_STEP_MV[i]) lvl = level_t'(CHG_STEP_LVL[i]);
      end
      if (shown < held_mv) shown = held_mv;
    end
    held_mv = shown;
    shown_level = lvl;
    r.charging = charger_seen;
    r.level = lvl;
    r.held_voltage = shown;
    r.changed = (lvl != was_level) || (charger_seen != was_charging);
  endtask

  task automatic check_field(input string field, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_below_mv = 14'd500;
      off_above_mv = 14'd1000;
      sense_mv = '0;
      batt_mv = '0;
      held_mv = 14'd4200;
      charger_seen = 1'b0;
      shown_level = 4'd10;
      readings_q.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{charging_o, level_o, held_voltage_o, changed_o};
        if (readings_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got charging %0d level %0d held %0d changed %0d",
                   $time, got.charging, got.level, got.held_voltage, got.changed);
          mismatches++;
        end else begin
          want = readings_q.pop_front();
          check_field("charging", want.charging, got.charging);
          check_field("level", want.level, got.level);
          check_field("held_voltage", want.held_voltage, got.held_voltage);
          check_field("changed", want.changed, got.changed);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CHARGE_ON_BELOW) on_below_mv = cfg_data_i;
        else if (cfg_idx_i == CFG_CHARGE_OFF_ABOVE) off_above_mv = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        track_sample(chan_e'(channel_i), raw_sample_i, next_reading);
        readings_q.push_back(next_reading);
      end
    end
  end

endmodule

>>> test/battery_level_indicator_core_tb.sv
// testbench top for the battery level indicator: stimulus, idling phases and verdict
`timescale 1ns / 100ps

module battery_level_indicator_core_tb
  import bli_pkg::*;
();

  localparam int PHASE_BEATS = 115;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [VoltW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ChanW-1:0]   channel_i = '0;
  logic [RawW-1:0]    raw_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               charging_o;
  logic [LevelW-1:0]  level_o;
  logic [VoltW-1:0]   held_voltage_o;
  logic               changed_o;
  int                 pending;
  int                 fail_count;

  int    send_idle_pct = 0;
  int    stall_pct = 0;
  volt_t cur_on_below = 14'd500;
  volt_t cur_off_above = 14'd1000;

  battery_level_indicator_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .channel_i, .raw_sample_i,
    .out_valid_o, .out_stall_i, .charging_o, .level_o, .held_voltage_o, .changed_o
  );

  battery_level_indicator_core_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .channel_i, .raw_sample_i,
    .out_valid_o, .out_stall_i, .charging_o, .level_o, .held_voltage_o, .changed_o,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // word that scales to mv (floored to a multiple of 3), low nibble random
  function automatic logic [RawW-1:0] raw_for_mv(int mv);
    int code;
    if (mv < 0) mv = 0;
    if (mv > 12285) mv = 12285;
    code = mv / 3;
    return {code[11:0], 4'($urandom_range(15))};
  endfunction

  task automatic send_sample(input chan_e ch, input logic [RawW-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i <= ch;
    raw_sample_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random_sample();
    int    pick;
    int    mv;
    chan_e ch;
    logic [RawW-1:0] raw;
    pick = $urandom_range(99);
    raw = 16'($urandom);
    if (pick < 40) begin
      ch = CH_BATT;
      // mostly around the ladders, where the level steps
      if ($urandom_range(9) < 8) raw = raw_for_mv($urandom_range(4220, 3550));
    end else if (pick < 75) begin
      ch = CH_SENSE;
      mv = $urandom_range(9);
      if (mv < 3) raw = raw_for_mv(int'(cur_on_below) + $urandom_range(60) - 30);
      else if (mv < 6) raw = raw_for_mv(int'(cur_off_above) + $urandom_range(60) - 30);
      else if (mv < 8) raw = raw_for_mv($urandom_range(1500));
    end else begin
      ch = (pick < 88) ? CH_AUX0 : CH_AUX1;
    end
    send_sample(ch, raw);
  endtask

  // sender holds off until every result beat is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_thresholds(input volt_t on_mv, input volt_t off_mv);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CHARGE_ON_BELOW;
    cfg_data_i <= on_mv;
    @(posedge clk_i);
    cfg_idx_i <= CFG_CHARGE_OFF_ABOVE;
    cfg_data_i <= off_mv;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_on_below = on_mv;
    cur_off_above = off_mv;
  endtask

  initial begin
    volt_t on_list  [6] = '{14'd500, 14'd0, 14'd12285, 14'd1200, 14'd0, 14'd0};
    volt_t off_list [6] = '{14'd1000, 14'd0, 14'd12285, 14'd600, 14'd12285, 14'd0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk at the reset thresholds
    send_sample(CH_AUX0, 16'h0000);
    send_sample(CH_AUX1, 16'hFFFF);
    send_sample(CH_BATT, 16'hFFFF);
    send_sample(CH_SENSE, 16'hFFFF);
    send_sample(CH_BATT, raw_for_mv(3939));
    send_sample(CH_BATT, raw_for_mv(3942));
    send_sample(CH_BATT, raw_for_mv(3600));
    send_sample(CH_BATT, raw_for_mv(3603));
    send_sample(CH_BATT, 16'h000F);
    send_sample(CH_SENSE, raw_for_mv(999));
    send_sample(CH_SENSE, raw_for_mv(1002));
    send_sample(CH_SENSE, raw_for_mv(498));
    send_sample(CH_BATT, raw_for_mv(4002));
    send_sample(CH_BATT, raw_for_mv(4074));
    send_sample(CH_BATT, raw_for_mv(4161));
    send_sample(CH_BATT, raw_for_mv(4023));
    send_sample(CH_SENSE, raw_for_mv(501));
    send_sample(CH_SENSE, 16'h0000);
    send_sample(CH_SENSE, raw_for_mv(1005));
    send_sample(CH_BATT, 16'h8000);
    send_sample(CH_AUX1, 16'h5A5A);

    on_list[5] = volt_t'($urandom_range(12285));
    off_list[5] = volt_t'($urandom_range(12285));
    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_thresholds(on_list[p], off_list[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == PHASE_BEATS / 2) drain_results();
        send_random_sample();
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("battery_level_indicator_core_tb passed");
    end else begin
      $display("battery_level_indicator_core_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("battery_level_indicator_core_tb failed");
    $finish;
  end

endmodule
